[hw/rtl/itprc_pkg.sv]
// types, constants and crc helper shared by the packet receiver files
package itprc_pkg;

    localparam int unsigned DEFAULT_DEPTH = 64;

    localparam logic [7:0]  IDLE_TICKS_RESET = 8'd5;
    localparam logic [7:0]  IDLE_COUNT_MAX   = 8'hFF;
    localparam logic [15:0] CRC_POLY         = 16'h1021;

    // command codes
    localparam logic [1:0] CMD_BYTE = 2'd0;
    localparam logic [1:0] CMD_TICK = 2'd1;
    localparam logic [1:0] CMD_ACK  = 2'd2;
    localparam logic [1:0] CMD_READ = 2'd3;

    // configuration register indexes
    localparam logic REG_IDLE_TICKS = 1'b0;
    localparam logic REG_CRC_ENABLE = 1'b1;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] rx_byte;
        logic [5:0] read_index;
    } in_item_t;

    typedef struct packed {
        logic [7:0]  read_data;
        logic [5:0]  packet_length;
        logic        data_available;
        logic        crc_match;
        logic [15:0] computed_crc;
        logic [15:0] trailer_crc;
        logic        error_code;
        logic        packet_ended;
    } out_item_t;

    // crc-16/xmodem, one byte msb first
    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] data);
        logic [15:0] c;
        c = crc ^ {data, 8'h00};
        for (int i = 0; i < 8; i++)
        begin
            if (c[15])
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

[hw/rtl/itprc_ram.sv]
// generic single-port-write ram with registered read
module itprc_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end

endmodule

[hw/rtl/idle_timeout_packet_receiver_crc_core.sv]
// idle-timeout packet receiver with crc-16/xmodem trailer check, top level
// byte, tick and acknowledge words: the result is registered from S_OUT; buffer read: S_READ, then S_OUT
// a tick that closes a packet of len > 2 bytes: S_CRC, S_FIN, S_OUT, with S_CRC held by the store's single
// read port walking the packet one byte a cycle; a closing tick on 1 or 2 bytes: S_FIN, then S_OUT
// next word is taken once the result is out
// rst_n is asynchronous: per-entry valid bits clear the whole store at once, no clearing pass
module idle_timeout_packet_receiver_crc_core #(
    parameter int unsigned BUFFER_DEPTH = itprc_pkg::DEFAULT_DEPTH
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  itprc_pkg::in_item_t  in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output itprc_pkg::out_item_t out_data,
    input  logic                 cfg_we,
    input  logic                 cfg_index,
    input  logic [7:0]           cfg_data
);

    localparam int unsigned AW = $clog2(BUFFER_DEPTH);
    localparam logic [AW-1:0] LAST_IDX = AW'(BUFFER_DEPTH - 1);
    localparam logic [AW-1:0] TWO      = AW'(2);
    localparam logic [AW-1:0] ONE      = AW'(1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_CRC,
        S_FIN,
        S_OUT
    } state_t;

    state_t state_reg, state_next;

    logic [7:0]              idle_ticks_reg;
    logic                    crc_en_reg;
    logic [BUFFER_DEPTH-1:0] valid_reg, valid_next;
    logic [AW-1:0]           wi_reg, wi_next;
    logic                    run_reg, run_next;
    logic [7:0]              cnt_reg, cnt_next;
    logic                    host_done_reg, host_done_next;
    logic                    avail_reg, avail_next;
    logic                    crc_ok_reg, crc_ok_next;
    logic [15:0]             crc_comp_reg, crc_comp_next;
    logic [15:0]             crc_recv_reg, crc_recv_next;
    logic                    err_reg, err_next;
    logic [7:0]              rdata_reg, rdata_next;
    logic                    ended_reg, ended_next;
    logic                    issue_reg, issue_next;
    logic [AW-1:0]           idx_reg, idx_next;
    logic                    pend_reg, pend_next;
    logic [AW-1:0]           pidx_reg, pidx_next;
    logic [15:0]             acc_reg, acc_next;
    logic [15:0]             trl_reg, trl_next;
    logic                    rd_vld_reg;
    logic                    out_valid_reg, out_valid_next;
    itprc_pkg::out_item_t    out_data_reg, out_data_next;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [7:0]    ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [7:0]    ram_q;

    logic [7:0]    cnt_inc;
    logic [7:0]    byte_q;
    logic          crc_ok;
    logic          accept;

    itprc_ram #(
        .WIDTH (8),
        .DEPTH (BUFFER_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_q)
    );

    assign in_stall  = (state_reg != S_IDLE);
    assign accept    = in_valid && (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign cnt_inc = (cnt_reg == itprc_pkg::IDLE_COUNT_MAX) ? cnt_reg : cnt_reg + 8'd1;
    // entries never written since the last flush read as zero
    assign byte_q  = rd_vld_reg ? ram_q : 8'h00;
    assign crc_ok  = (wi_reg > TWO) && (acc_reg == trl_reg);

    always_comb
    begin
        state_next     = state_reg;
        valid_next     = valid_reg;
        wi_next        = wi_reg;
        run_next       = run_reg;
        cnt_next       = cnt_reg;
        host_done_next = host_done_reg;
        avail_next     = avail_reg;
        crc_ok_next    = crc_ok_reg;
        crc_comp_next  = crc_comp_reg;
        crc_recv_next  = crc_recv_reg;
        err_next       = err_reg;
        rdata_next     = rdata_reg;
        ended_next     = ended_reg;
        issue_next     = issue_reg;
        idx_next       = idx_reg;
        pend_next      = 1'b0;
        pidx_next      = pidx_reg;
        acc_next       = acc_reg;
        trl_next       = trl_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_data_next  = out_data_reg;
        ram_we         = 1'b0;
        ram_waddr      = wi_reg;
        ram_wdata      = in_data.rx_byte;
        ram_raddr      = idx_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    rdata_next = 8'h00;
                    ended_next = 1'b0;
                    state_next = S_OUT;
                    unique case (in_data.cmd)
                        itprc_pkg::CMD_BYTE:
                        begin
                            if (!err_reg)
                            begin
                                ram_we             = 1'b1;
                                valid_next[wi_reg] = 1'b1;
                                wi_next = (wi_reg == LAST_IDX) ? '0 : wi_reg + ONE;
                            end
                            cnt_next = 8'h00;
                            run_next = 1'b1;
                        end
                        itprc_pkg::CMD_TICK:
                        begin
                            if (run_reg)
                            begin
                                if (cnt_inc >= idle_ticks_reg)
                                begin
                                    run_next = 1'b0;
                                    cnt_next = 8'h00;
                                    if (wi_reg != '0)
                                    begin
                                        ended_next = 1'b1;
                                        acc_next   = 16'h0000;
                                        idx_next   = '0;
                                        if (wi_reg > TWO)
                                        begin
                                            issue_next = 1'b1;
                                            state_next = S_CRC;
                                        end
                                        else
                                            state_next = S_FIN;
                                    end
                                end
                                else
                                    cnt_next = cnt_inc;
                            end
                        end
                        itprc_pkg::CMD_ACK:
                        begin
                            valid_next     = '0;
                            wi_next        = '0;
                            avail_next     = 1'b0;
                            host_done_next = 1'b1;
                            err_next       = 1'b0;
                        end
                        itprc_pkg::CMD_READ:
                        begin
                            if (32'(in_data.read_index) < BUFFER_DEPTH)
                            begin
                                ram_raddr  = AW'(in_data.read_index);
                                state_next = S_READ;
                            end
                        end
                        default:
                        begin
                            state_next = S_OUT;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                rdata_next = byte_q;
                state_next = S_OUT;
            end
            S_CRC:
            begin
                // one read issued per cycle, data lands in the cycle after the read
                if (issue_reg)
                begin
                    pend_next = 1'b1;
                    pidx_next = idx_reg;
                    if (idx_reg == wi_reg - ONE)
                        issue_next = 1'b0;
                    else
                        idx_next = idx_reg + ONE;
                end
                if (pend_reg)
                begin
                    if (pidx_reg < wi_reg - TWO)
                        acc_next = itprc_pkg::crc_feed(acc_reg, byte_q);
                    else if (pidx_reg == wi_reg - TWO)
                        trl_next = {byte_q, trl_reg[7:0]};
                    else
                        trl_next = {trl_reg[15:8], byte_q};
                    if (pidx_reg == wi_reg - ONE)
                        state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                crc_ok_next = crc_ok;
                if (wi_reg > TWO)
                begin
                    crc_comp_next = acc_reg;
                    crc_recv_next = trl_reg;
                end
                if (crc_en_reg && !crc_ok)
                begin
                    valid_next = '0;
                    wi_next    = '0;
                    avail_next = 1'b0;
                    err_next   = 1'b0;
                end
                else
                begin
                    avail_next = 1'b1;
                    err_next   = err_reg || !host_done_reg;
                end
                host_done_next = 1'b0;
                state_next     = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next                = 1'b1;
                    out_data_next.read_data      = rdata_reg;
                    out_data_next.packet_length  = 6'(wi_reg);
                    out_data_next.data_available = avail_reg;
                    out_data_next.crc_match      = crc_ok_reg;
                    out_data_next.computed_crc   = crc_comp_reg;
                    out_data_next.trailer_crc    = crc_recv_reg;
                    out_data_next.error_code     = err_reg;
                    out_data_next.packet_ended   = ended_reg;
                    state_next                    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            idle_ticks_reg <= itprc_pkg::IDLE_TICKS_RESET;
            crc_en_reg     <= 1'b0;
            valid_reg      <= '0;
            wi_reg         <= '0;
            run_reg        <= 1'b0;
            cnt_reg        <= 8'h00;
            host_done_reg  <= 1'b1;
            avail_reg      <= 1'b0;
            crc_ok_reg     <= 1'b0;
            crc_comp_reg   <= 16'h0000;
            crc_recv_reg   <= 16'h0000;
            err_reg        <= 1'b0;
            rdata_reg      <= 8'h00;
            ended_reg      <= 1'b0;
            issue_reg      <= 1'b0;
            idx_reg        <= '0;
            pend_reg       <= 1'b0;
            pidx_reg       <= '0;
            acc_reg        <= 16'h0000;
            trl_reg        <= 16'h0000;
            rd_vld_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_data_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            wi_reg        <= wi_next;
            run_reg       <= run_next;
            cnt_reg       <= cnt_next;
            host_done_reg <= host_done_next;
            avail_reg     <= avail_next;
            crc_ok_reg    <= crc_ok_next;
            crc_comp_reg  <= crc_comp_next;
            crc_recv_reg  <= crc_recv_next;
            err_reg       <= err_next;
            rdata_reg     <= rdata_next;
            ended_reg     <= ended_next;
            issue_reg     <= issue_next;
            idx_reg       <= idx_next;
            pend_reg      <= pend_next;
            pidx_reg      <= pidx_next;
            acc_reg       <= acc_next;
            trl_reg       <= trl_next;
            rd_vld_reg    <= valid_reg[ram_raddr];
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    itprc_pkg::REG_IDLE_TICKS: idle_ticks_reg <= cfg_data;
                    itprc_pkg::REG_CRC_ENABLE: crc_en_reg     <= cfg_data[0];
                    default:                   idle_ticks_reg <= idle_ticks_reg;
                endcase
            end
        end
    end

endmodule

[hw/rtl/itprc_chk.sv]
// port-level checks for the packet receiver, bound to the top level
module itprc_chk (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_stall,
    input itprc_pkg::in_item_t  in_data,
    input logic                 out_valid,
    input logic                 out_stall,
    input itprc_pkg::out_item_t out_data
);

    // a stalled input word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(in_data))
        else $error("input word changed while stalled");

    // a stalled result word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("result word changed while stalled");

    // an error is only raised on a packet that was kept
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.error_code |-> out_data.data_available)
        else $error("error flagged without an available packet");

    // a closed packet that is not available was flushed
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.packet_ended && !out_data.data_available
        |-> out_data.packet_length == 6'd0 && !out_data.error_code)
        else $error("discarded packet left data or error behind");

    // a matching crc never discards the packet
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.packet_ended && out_data.crc_match
        |-> out_data.data_available)
        else $error("packet with matching crc not available");

endmodule

bind idle_timeout_packet_receiver_crc_core itprc_chk u_itprc_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

[tb/tb.sv]
// self-checking testbench for the idle-timeout packet receiver with crc trailer check
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    itprc_pkg::in_item_t  in_data = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    itprc_pkg::out_item_t out_data;
    logic                 cfg_we = 1'b0;
    logic                 cfg_index = 1'b0;
    logic [7:0]           cfg_data = 8'd0;

    idle_timeout_packet_receiver_crc_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // words waiting to be sent, results still owed by the block
    itprc_pkg::in_item_t  tx_words[$];
    itprc_pkg::out_item_t due_results[$];
    int        errors = 0;
    int        pushed = 0;
    bit        no_idle = 1'b0;
    bit        drv_busy;
    int        drv_gap = 0;
    int        mon_hold = 0;

    // receiver state as the block should hold it
    logic [7:0]  m_store [0:63];
    logic [5:0]  m_wr;
    logic        m_idle_on;
    logic [7:0]  m_idle_cnt;
    logic        m_host_done;
    logic        m_avail;
    logic        m_crc_ok;
    logic [15:0] m_crc_calc;
    logic [15:0] m_crc_trail;
    logic        m_err;
    logic [7:0]  m_idle_ticks;
    logic        m_crc_on;

    function automatic logic [15:0] xmodem_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int k = 7; k >= 0; k--)
        begin
            fb = c[15] ^ b[k];
            c = {c[14:0], 1'b0};
            if (fb)
                c = c ^ itprc_pkg::CRC_POLY;
        end
        return c;
    endfunction

    function automatic void flush_store();
        for (int i = 0; i < 64; i++)
            m_store[i] = 8'd0;
        m_wr = '0;
        m_avail = 1'b0;
        m_host_done = 1'b1;
        m_err = 1'b0;
    endfunction

    function automatic void receiver_reset();
        flush_store();
        m_idle_on = 1'b0;
        m_idle_cnt = 8'd0;
        m_crc_ok = 1'b0;
        m_crc_calc = 16'd0;
        m_crc_trail = 16'd0;
        m_idle_ticks = itprc_pkg::IDLE_TICKS_RESET;
        m_crc_on = 1'b0;
    endfunction

    function automatic void close_packet();
        int          len;
        logic [15:0] c;
        len = int'(m_wr);
        if (!m_host_done)
            m_err = 1'b1;
        m_crc_ok = 1'b0;
        // two bytes or fewer: no crc, the match flag clears, computed and trailer crc keep their old values
        if (len > 2)
        begin
            c = 16'd0;
            for (int i = 0; i < len - 2; i++)
                c = xmodem_step(c, m_store[i]);
            m_crc_calc = c;
            m_crc_trail = {m_store[len - 2], m_store[len - 1]};
            m_crc_ok = (c == m_crc_trail);
        end
        if (m_crc_on && !m_crc_ok)
            flush_store();
        else
            m_avail = 1'b1;
        m_host_done = 1'b0;
    endfunction

    function automatic itprc_pkg::out_item_t receiver_step(input itprc_pkg::in_item_t w);
        itprc_pkg::out_item_t r;
        r = '0;
        case (w.cmd)
            itprc_pkg::CMD_BYTE:
            begin
                // dropped while the error flag is up, the idle count restarts anyway
                if (!m_err)
                begin
                    m_store[m_wr] = w.rx_byte;
                    m_wr = m_wr + 6'd1;
                end
                m_idle_cnt = 8'd0;
                m_idle_on = 1'b1;
            end
            itprc_pkg::CMD_TICK:
            begin
                if (m_idle_on)
                begin
                    if (m_idle_cnt != itprc_pkg::IDLE_COUNT_MAX)
                        m_idle_cnt = m_idle_cnt + 8'd1;
                    if (m_idle_cnt >= m_idle_ticks)
                    begin
                        m_idle_on = 1'b0;
                        m_idle_cnt = 8'd0;
                        if (m_wr != 6'd0)
                        begin
                            close_packet();
                            r.packet_ended = 1'b1;
                        end
                    end
                end
            end
            itprc_pkg::CMD_ACK:
                flush_store();
            itprc_pkg::CMD_READ:
                r.read_data = m_store[w.read_index];
            default:
                ;
        endcase
        r.packet_length = m_wr;
        r.data_available = m_avail;
        r.crc_match = m_crc_ok;
        r.computed_crc = m_crc_calc;
        r.trailer_crc = m_crc_trail;
        r.error_code = m_err;
        return r;
    endfunction

    function automatic void cmp_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            errors++;
        end
    endfunction

    function automatic void check_result(input itprc_pkg::out_item_t got);
        itprc_pkg::out_item_t want;
        if (due_results.size() == 0)
        begin
            $error("result word with nothing outstanding");
            errors++;
            return;
        end
        want = due_results.pop_front();
        cmp_field("read_data", 16'(want.read_data), 16'(got.read_data));
        cmp_field("packet_length", 16'(want.packet_length), 16'(got.packet_length));
        cmp_field("data_available", 16'(want.data_available), 16'(got.data_available));
        cmp_field("crc_match", 16'(want.crc_match), 16'(got.crc_match));
        cmp_field("computed_crc", want.computed_crc, got.computed_crc);
        cmp_field("trailer_crc", want.trailer_crc, got.trailer_crc);
        cmp_field("error_code", 16'(want.error_code), 16'(got.error_code));
        cmp_field("packet_ended", 16'(want.packet_ended), 16'(got.packet_ended));
    endfunction

    // driver: one word at a time from tx_words, random gap before each
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data <= '0;
            drv_gap = 0;
        end
        else
        begin
            drv_busy = in_valid;
            if (in_valid && !in_stall)
            begin
                due_results.push_back(receiver_step(in_data));
                drv_busy = 1'b0;
            end
            if (!drv_busy)
            begin
                if (drv_gap > 0)
                    drv_gap--;
                else if (tx_words.size() != 0)
                begin
                    in_data <= tx_words.pop_front();
                    drv_busy = 1'b1;
                    drv_gap = no_idle ? 0 : int'($urandom_range(0, 9));
                end
            end
            in_valid <= drv_busy;
        end
    end

    // monitor: checks each result word, then stalls for a random while
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            mon_hold = 0;
        end
        else
        begin
            if ($isunknown(out_valid))
            begin
                $error("out_valid unknown");
                errors++;
            end
            if (out_valid && !out_stall)
            begin
                check_result(out_data);
                mon_hold = no_idle ? 0 : int'($urandom_range(0, 9));
            end
            else if (mon_hold > 0)
                mon_hold--;
            out_stall <= (mon_hold > 0);
        end
    end

    task automatic push_word(input logic [1:0] cmd, input logic [7:0] val);
        itprc_pkg::in_item_t w;
        w.cmd = cmd;
        w.rx_byte = 8'($urandom);
        w.read_index = 6'($urandom);
        if (cmd == itprc_pkg::CMD_BYTE)
            w.rx_byte = val;
        else if (cmd == itprc_pkg::CMD_READ)
            w.read_index = val[5:0];
        tx_words.push_back(w);
        pushed++;
    endtask

    task automatic push_ticks(input int n);
        repeat (n) push_word(itprc_pkg::CMD_TICK, 8'($urandom));
    endtask

    task automatic wait_idle(input int settle);
        do
            @(posedge clk);
        while (tx_words.size() != 0 || in_valid || due_results.size() != 0);
        repeat (settle) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [7:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == itprc_pkg::REG_IDLE_TICKS)
            m_idle_ticks = val;
        else
            m_crc_on = val[0];
    endtask

    // one packet with a trailer, sometimes corrupted or interrupted, or a burst of noise
    task automatic packet_round();
        int          n;
        int          r;
        int          k;
        logic [15:0] c;
        logic [7:0]  b;
        no_idle = ($urandom_range(0, 4) == 0);
        r = int'($urandom_range(0, 99));
        if (r < 10)
        begin
            repeat ($urandom_range(1, 6))
                push_word(2'($urandom_range(0, 3)), 8'($urandom));
            return;
        end
        k = int'($urandom_range(0, 19));
        if (k == 0)
            n = int'($urandom_range(40, 63));
        else if (k == 1)
            n = int'($urandom_range(0, 1));
        else
            n = int'($urandom_range(1, 14));
        c = 16'd0;
        for (int i = 0; i < n; i++)
        begin
            if (r >= 25 && r < 35 && i == n / 2 && m_idle_ticks > 8'd1)
                push_ticks(int'($urandom_range(1, 32'(m_idle_ticks) - 1)));
            b = 8'($urandom);
            c = xmodem_step(c, b);
            push_word(itprc_pkg::CMD_BYTE, b);
        end
        if (r < 25)
            c = c ^ 16'($urandom_range(1, 65535));
        push_word(itprc_pkg::CMD_BYTE, c[15:8]);
        push_word(itprc_pkg::CMD_BYTE, c[7:0]);
        k = int'(m_idle_ticks) + int'($urandom_range(0, 2));
        push_ticks(k == 0 ? 1 : k);
        repeat ($urandom_range(0, 3))
            push_word(itprc_pkg::CMD_READ,
                      8'($urandom_range(0, 3) == 0 ? $urandom_range(0, 63)
                                                   : $urandom_range(0, n + 1)));
        if ($urandom_range(0, 99) < 85)
            push_word(itprc_pkg::CMD_ACK, 8'($urandom));
    endtask

    task automatic run_phase(input logic [7:0] idle, input logic crc_on, input int budget);
        int start;
        wait_idle(8);
        write_reg(itprc_pkg::REG_IDLE_TICKS, idle);
        write_reg(itprc_pkg::REG_CRC_ENABLE, {7'd0, crc_on});
        start = pushed;
        while (pushed - start < budget)
        begin
            packet_round();
            if ($urandom_range(0, 19) == 0)
                wait_idle(0);
        end
    endtask

    initial
    begin
        receiver_reset();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed words at the reset settings
        push_word(itprc_pkg::CMD_READ, 8'd63);
        push_word(itprc_pkg::CMD_TICK, 8'd0);
        push_word(itprc_pkg::CMD_ACK, 8'd0);
        push_word(itprc_pkg::CMD_BYTE, 8'hFF);
        push_word(itprc_pkg::CMD_BYTE, 8'h00);
        push_ticks(5);
        push_word(itprc_pkg::CMD_READ, 8'd0);
        // second packet on top of an unacknowledged one raises the error flag
        push_word(itprc_pkg::CMD_BYTE, 8'hA5);
        push_ticks(5);
        push_word(itprc_pkg::CMD_BYTE, 8'h11);
        push_word(itprc_pkg::CMD_ACK, 8'd0);
        // timeout with an empty store
        push_ticks(5);

        run_phase(8'd1, 1'b1, 200);
        run_phase(8'd3, 1'b0, 200);
        run_phase(8'd255, 1'b1, 150);
        run_phase(8'd0, 1'b0, 150);
        run_phase(8'd2, 1'b1, 200);
        run_phase(8'($urandom_range(1, 8)), 1'($urandom_range(0, 1)), 150);
        wait_idle(80);

        if (errors == 0)
            $display("PASS idle_timeout_packet_receiver_crc_core");
        else
            $display("FAIL idle_timeout_packet_receiver_crc_core");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("FAIL idle_timeout_packet_receiver_crc_core");
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/itprc_pkg.sv
hw/rtl/itprc_ram.sv
hw/rtl/idle_timeout_packet_receiver_crc_core.sv
hw/rtl/itprc_chk.sv
tb/tb.sv
